// File: design/tbc_pkg.sv
// shared types, codes and helpers for the tone beeper controller
package tbc_pkg;

  // field widths
  localparam int unsigned CLK_W  = 21;
  localparam int unsigned FREQ_W = 16;
  localparam int unsigned MS_W   = 16;
  localparam int unsigned DIV_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // largest divisor the tone timer can hold
  localparam int unsigned DIVISOR_MAX = 65535;
  localparam int unsigned DIVISOR_MIN = 2;

  // one quotient bit per divider step
  localparam int unsigned DIV_STEPS = CLK_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // configuration register reset values
  localparam logic [CLK_W-1:0]  TCLK_RST = CLK_W'(1193182);
  localparam logic [FREQ_W-1:0] FMIN_RST = FREQ_W'(20);
  localparam logic [FREQ_W-1:0] FMAX_RST = FREQ_W'(20000);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMER_CLOCK = 2'd0,
    CFG_MIN_FREQ    = 2'd1,
    CFG_MAX_FREQ    = 2'd2
  } cfg_idx_e;

  // command codes
  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_PLAY = 2'd1,
    CMD_STOP = 2'd2,
    CMD_BEEP = 2'd3
  } cmd_e;

  // sound state codes
  typedef enum logic [1:0] {
    SND_OFF     = 2'd0,
    SND_PLAYING = 2'd1,
    SND_BEEPING = 2'd2
  } sound_e;

  // controller sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DIV  = 1'b1
  } state_e;

  // one result beat
  typedef struct packed {
    logic             accepted;
    logic [1:0]       sound_state;
    logic             speaker_gate;
    logic [DIV_W-1:0] divisor;
    logic             divisor_loaded;
  } res_t;

  // clamp a raw quotient into the timer's divisor range
  function automatic logic [DIV_W-1:0] clamp_divisor(input logic [CLK_W-1:0] q);
    logic [DIV_W-1:0] r;
    if (q < CLK_W'(DIVISOR_MIN)) begin
      r = DIV_W'(DIVISOR_MIN);
    end else if (q > CLK_W'(DIVISOR_MAX)) begin
      r = DIV_W'(DIVISOR_MAX);
    end else begin
      r = q[DIV_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: design/tbc_if.sv
// command and result channel interfaces
interface tbc_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                command;
  logic [tbc_pkg::FREQ_W-1:0] frequency;
  logic [tbc_pkg::MS_W-1:0]  duration_ms;

  modport source (output valid, output command, output frequency, output duration_ms,
                  input ready);
  modport sink (input valid, input command, input frequency, input duration_ms,
                output ready);
endinterface

interface tbc_res_if;
  logic                      valid;
  logic                      ready;
  logic                      accepted;
  logic [1:0]                sound_state;
  logic                      speaker_gate;
  logic [tbc_pkg::DIV_W-1:0] divisor;
  logic                      divisor_loaded;

  modport source (output valid, output accepted, output sound_state, output speaker_gate,
                  output divisor, output divisor_loaded, input ready);
  modport sink (input valid, input accepted, input sound_state, input speaker_gate,
                input divisor, input divisor_loaded, output ready);
endinterface

// File: design/tone_beeper_controller.sv
// top level of the tone beeper controller: command decode, state and result path
//
//  channel   dir  beat contents
//  cmd_i     in   command, frequency, duration_ms
//  res_o     out  accepted, sound_state, speaker_gate, divisor, divisor_loaded
//  cfg_*     in   register index and write data, no handshake
//
// a command that loads a new divisor shows its result once the divide ends:
// the bit-serial divider produces one quotient bit per cycle over the 21-bit timer clock.
// every other command passes through the result buffer then the output register.
// a new command is taken once the result buffer has passed its beat on, so it
// can be accepted while the previous result still waits on res_o.
// reset clears the tone state and loads the register defaults.
module tone_beeper_controller (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tbc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tbc_pkg::CLK_W-1:0]         cfg_data_i,
  tbc_cmd_if.sink                           cmd_i,
  tbc_res_if.source                         res_o
);
  import tbc_pkg::*;

  state_e            state_q, state_d;
  logic [CLK_W-1:0]  tclk_q;
  logic [FREQ_W-1:0] fmin_q, fmax_q;
  sound_e            snd_q, snd_d;
  logic [FREQ_W-1:0] pf_q, pf_d;
  logic [MS_W-1:0]   rem_q, rem_d;
  logic              gate_q, gate_d;
  logic [DIV_W-1:0]  div_q;
  res_t              res_q, out_q;
  logic              res_vld_q, out_vld_q;

  logic              cmd_acc;
  logic              acc_n;
  logic              need_div;
  logic              in_range;
  logic              same_tone;
  logic              div_start;
  logic              div_done;
  logic [CLK_W-1:0]  quot;
  logic [DIV_W-1:0]  quot_clamped;
  logic              out_free;

  assign cmd_acc      = cmd_i.valid && cmd_i.ready;
  assign out_free     = !out_vld_q || res_o.ready;
  assign quot_clamped = clamp_divisor(quot);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tclk_q <= TCLK_RST;
      fmin_q <= FMIN_RST;
      fmax_q <= FMAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TIMER_CLOCK: tclk_q <= cfg_data_i;
        CFG_MIN_FREQ:    fmin_q <= cfg_data_i[FREQ_W-1:0];
        CFG_MAX_FREQ:    fmax_q <= cfg_data_i[FREQ_W-1:0];
        default:         ;
      endcase
    end
  end

  // command decode: tone state after this command
  always_comb begin
    in_range  = (cmd_i.frequency >= fmin_q) && (cmd_i.frequency <= fmax_q);
    same_tone = (snd_q == SND_PLAYING) && (pf_q == cmd_i.frequency);
    snd_d     = snd_q;
    pf_d      = pf_q;
    rem_d     = rem_q;
    gate_d    = gate_q;
    acc_n     = 1'b1;
    need_div  = 1'b0;
    unique case (cmd_e'(cmd_i.command))
      CMD_TICK: begin
        if (snd_q == SND_BEEPING) begin
          if (rem_q <= MS_W'(1)) begin
            snd_d  = SND_OFF;
            pf_d   = '0;
            rem_d  = '0;
            gate_d = 1'b0;
          end else begin
            rem_d = rem_q - 1'b1;
          end
        end
      end
      CMD_PLAY: begin
        if (!in_range) begin
          acc_n = 1'b0;
        end else if (!same_tone) begin
          snd_d    = SND_PLAYING;
          pf_d     = cmd_i.frequency;
          rem_d    = '0;
          gate_d   = 1'b1;
          need_div = 1'b1;
        end
      end
      CMD_STOP: begin
        snd_d  = SND_OFF;
        pf_d   = '0;
        rem_d  = '0;
        gate_d = 1'b0;
      end
      CMD_BEEP: begin
        if (!in_range || (cmd_i.duration_ms == '0)) begin
          acc_n = 1'b0;
        end else begin
          snd_d    = SND_BEEPING;
          pf_d     = cmd_i.frequency;
          rem_d    = cmd_i.duration_ms;
          gate_d   = 1'b1;
          need_div = !same_tone;
        end
      end
      default: ;
    endcase
  end

  // tone state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snd_q  <= SND_OFF;
      pf_q   <= '0;
      rem_q  <= '0;
      gate_q <= 1'b0;
      div_q  <= '0;
    end else begin
      if (cmd_acc) begin
        snd_q  <= snd_d;
        pf_q   <= pf_d;
        rem_q  <= rem_d;
        gate_q <= gate_d;
      end
      if (div_done) begin
        div_q <= quot_clamped;
      end
    end
  end

  // divisor computation
  tbc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (tclk_q),
    .divisor_i  (cmd_i.frequency),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (cmd_acc && need_div) state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd_i.ready = (state_q == ST_IDLE) && !res_vld_q;
    div_start   = cmd_acc && need_div;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // result buffer payload: fields at accept, divisor when the divide ends
  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      res_q.accepted       <= acc_n;
      res_q.sound_state    <= snd_d;
      res_q.speaker_gate   <= gate_d;
      res_q.divisor        <= div_q;
      res_q.divisor_loaded <= need_div;
    end else if (div_done) begin
      res_q.divisor <= quot_clamped;
    end
  end

  // result buffer valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (cmd_acc && !need_div) begin
      res_vld_q <= 1'b1;
    end else if (div_done) begin
      res_vld_q <= 1'b1;
    end else if (res_vld_q && out_free) begin
      res_vld_q <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_vld_q && out_free) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld_q && out_free) begin
      out_q <= res_q;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.accepted       = out_q.accepted;
  assign res_o.sound_state    = out_q.sound_state;
  assign res_o.speaker_gate   = out_q.speaker_gate;
  assign res_o.divisor        = out_q.divisor;
  assign res_o.divisor_loaded = out_q.divisor_loaded;

endmodule

// File: design/tbc_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
module tbc_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tbc_pkg::CLK_W-1:0]   dividend_i,
  input  logic [tbc_pkg::FREQ_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [tbc_pkg::CLK_W-1:0]   quotient_o
);
  import tbc_pkg::*;

  logic                  busy_q;
  logic                  done_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic [CLK_W-1:0]      acc_q, acc_d;
  logic [FREQ_W-1:0]     rem_q, rem_d;
  logic [FREQ_W-1:0]     dvs_q;
  logic [FREQ_W:0]       trial;
  logic [FREQ_W:0]       diff;
  logic                  fits;

  // one restoring step: shift in the next dividend bit, try the subtract
  always_comb begin
    trial = {rem_q, acc_q[CLK_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});
    rem_d = fits ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
    acc_d = {acc_q[CLK_W-2:0], fits};
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = acc_q;

endmodule

// File: tb/tb.sv
// self-checking testbench for the tone beeper controller: directed and random commands
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tbc_pkg::*;

  // one command beat as the driver sends it
  typedef struct {
    cmd_e              cmd;
    logic [FREQ_W-1:0] freq;
    logic [MS_W-1:0]   ms;
  } beeper_cmd_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  cfg_idx_e         cfg_index;
  logic [CLK_W-1:0] cfg_data;

  tbc_cmd_if cmd_bus ();
  tbc_res_if res_bus ();

  tone_beeper_controller dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .cmd_i      (cmd_bus),
    .res_o      (res_bus)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // predicted register and tone state
  logic [CLK_W-1:0]  tclk_hz;
  logic [FREQ_W-1:0] f_lo;
  logic [FREQ_W-1:0] f_hi;
  sound_e            snd;
  logic [FREQ_W-1:0] tone_freq;
  logic [MS_W-1:0]   beep_left;
  logic [DIV_W-1:0]  tone_div;
  logic              gate;

  beeper_cmd_t cmd_backlog[$];
  res_t        expected_reports[$];
  int          cmd_queued = 0;
  int          cmd_taken = 0;
  int          errors = 0;
  logic        cmd_fire = 1'b0;
  int          burst_left = 1;
  int          gap_left = 0;
  int          rx_phase = 0;

  // timer divisor for a tone, a zero frequency saturates
  function automatic logic [DIV_W-1:0] divisor_of(logic [FREQ_W-1:0] f);
    int unsigned q;
    if (f == '0) return DIV_W'(DIVISOR_MAX);
    q = tclk_hz / f;
    if (q < DIVISOR_MIN) q = DIVISOR_MIN;
    else if (q > DIVISOR_MAX) q = DIVISOR_MAX;
    return DIV_W'(q);
  endfunction

  // gate off and forget the tone, the divisor stays
  function automatic void silence();
    if (snd != SND_OFF) begin
      gate = 1'b0;
      snd = SND_OFF;
      tone_freq = '0;
      beep_left = '0;
    end
  endfunction

  // start a tone, returns 1 when a divisor gets loaded
  function automatic logic tone_on(logic [FREQ_W-1:0] f);
    if (snd == SND_PLAYING && tone_freq == f) return 1'b0;
    silence();
    tone_div = divisor_of(f);
    gate = 1'b1;
    snd = SND_PLAYING;
    tone_freq = f;
    beep_left = '0;
    return 1'b1;
  endfunction

  // next tone state and the report one command produces
  function automatic res_t beeper_next(beeper_cmd_t c);
    res_t r;
    logic ok;
    logic ld;
    logic in_band;
    ok = 1'b1;
    ld = 1'b0;
    in_band = (c.freq >= f_lo) && (c.freq <= f_hi);
    case (c.cmd)
      CMD_TICK: begin
        if (snd == SND_BEEPING) begin
          if (beep_left != '0) beep_left = beep_left - 1'b1;
          if (beep_left == '0) silence();
        end
      end
      CMD_PLAY: begin
        if (in_band) ld = tone_on(c.freq);
        else ok = 1'b0;
      end
      CMD_STOP: begin
        silence();
      end
      CMD_BEEP: begin
        if (in_band && c.ms != '0) begin
          ld = tone_on(c.freq);
          snd = SND_BEEPING;
          beep_left = c.ms;
        end else begin
          ok = 1'b0;
        end
      end
    endcase
    r.accepted = ok;
    r.sound_state = snd;
    r.speaker_gate = gate;
    r.divisor = tone_div;
    r.divisor_loaded = ld;
    return r;
  endfunction

  task automatic check_field(string name, logic [DIV_W-1:0] want, logic [DIV_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // monitor: check result beats, predict on command beats
  always @(posedge clk_i) begin : monitor
    res_t        want;
    beeper_cmd_t beat;
    cmd_fire = rst_ni && cmd_bus.valid && cmd_bus.ready;
    if (rst_ni) begin
      if (res_bus.valid && res_bus.ready) begin
        if (expected_reports.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none, actual div %0d state %0d",
                   $time, res_bus.divisor, res_bus.sound_state);
        end else begin
          want = expected_reports.pop_front();
          check_field("accepted", DIV_W'(want.accepted), DIV_W'(res_bus.accepted));
          check_field("sound_state", DIV_W'(want.sound_state), DIV_W'(res_bus.sound_state));
          check_field("speaker_gate", DIV_W'(want.speaker_gate), DIV_W'(res_bus.speaker_gate));
          check_field("divisor", want.divisor, res_bus.divisor);
          check_field("divisor_loaded", DIV_W'(want.divisor_loaded),
                      DIV_W'(res_bus.divisor_loaded));
        end
      end
      if (cmd_fire) begin
        beat.cmd = cmd_e'(cmd_bus.command);
        beat.freq = cmd_bus.frequency;
        beat.ms = cmd_bus.duration_ms;
        expected_reports.push_back(beeper_next(beat));
        cmd_taken++;
      end
    end
  end

  // driver: bursts of command beats with random gaps
  always @(negedge clk_i) begin : driver
    beeper_cmd_t nxt;
    if (!rst_ni) begin
      cmd_bus.valid <= 1'b0;
    end else if (!cmd_bus.valid || cmd_fire) begin
      if (gap_left != 0) begin
        gap_left--;
        cmd_bus.valid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        nxt = cmd_backlog.pop_front();
        cmd_bus.valid <= 1'b1;
        cmd_bus.command <= nxt.cmd;
        cmd_bus.frequency <= nxt.freq;
        cmd_bus.duration_ms <= nxt.ms;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        cmd_bus.valid <= 1'b0;
      end
    end
  end

  // receiver: cycles through stall patterns
  always @(negedge clk_i) begin
    rx_phase++;
    case (rx_phase[9:8])
      2'd0: res_bus.ready <= 1'b1;
      2'd1: res_bus.ready <= ($urandom_range(0, 3) != 0);
      2'd2: res_bus.ready <= (rx_phase[4:0] >= 5'd12);
      default: res_bus.ready <= $urandom_range(0, 1);
    endcase
  end

  task automatic add_cmd(cmd_e c, logic [FREQ_W-1:0] f, logic [MS_W-1:0] ms);
    beeper_cmd_t b;
    b.cmd = c;
    b.freq = f;
    b.ms = ms;
    cmd_backlog.push_back(b);
    cmd_queued++;
  endtask

  // random commands, mostly in band, often repeating a recent tone
  task automatic add_random(int n);
    int unsigned       pick;
    cmd_e              c;
    logic [FREQ_W-1:0] f;
    logic [MS_W-1:0]   ms;
    logic [FREQ_W-1:0] recent;
    recent = f_lo;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      c = (pick < 35) ? CMD_TICK : (pick < 62) ? CMD_PLAY : (pick < 72) ? CMD_STOP : CMD_BEEP;
      pick = $urandom_range(0, 9);
      if (pick < 6 && f_lo <= f_hi) f = FREQ_W'($urandom_range(f_lo, f_hi));
      else if (pick < 8) f = recent;
      else f = FREQ_W'($urandom);
      if ($urandom_range(0, 2) == 0) recent = f;
      pick = $urandom_range(0, 19);
      ms = (pick == 0) ? MS_W'(0) : (pick == 1) ? MS_W'($urandom) :
           (pick == 2) ? MS_W'(65535) : MS_W'($urandom_range(1, 6));
      add_cmd(c, f, ms);
    end
  endtask

  // wait until every command has been taken and answered
  task automatic drain();
    while (cmd_taken != cmd_queued || expected_reports.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CLK_W-1:0] v);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    @(posedge clk_i);
    case (idx)
      CFG_TIMER_CLOCK: tclk_hz = v;
      CFG_MIN_FREQ:    f_lo = v[FREQ_W-1:0];
      CFG_MAX_FREQ:    f_hi = v[FREQ_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [CLK_W-1:0] hz, logic [FREQ_W-1:0] lo, logic [FREQ_W-1:0] hi);
    write_reg(CFG_TIMER_CLOCK, hz);
    write_reg(CFG_MIN_FREQ, CLK_W'(lo));
    write_reg(CFG_MAX_FREQ, CLK_W'(hi));
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // stimulus and end of run
  initial begin : stimulus
    logic [FREQ_W-1:0] lo;
    cfg_we = 1'b0;
    cfg_index = CFG_TIMER_CLOCK;
    cfg_data = '0;
    cmd_bus.valid = 1'b0;
    cmd_bus.command = CMD_TICK;
    cmd_bus.frequency = '0;
    cmd_bus.duration_ms = '0;
    res_bus.ready = 1'b0;
    rst_ni = 1'b0;
    tclk_hz = TCLK_RST;
    f_lo = FMIN_RST;
    f_hi = FMAX_RST;
    snd = SND_OFF;
    tone_freq = '0;
    beep_left = '0;
    tone_div = '0;
    gate = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: band edges, same tone, replace, beep countdown, stop when off
    add_cmd(CMD_TICK, 16'd0, 16'd0);
    add_cmd(CMD_STOP, 16'd0, 16'd0);
    add_cmd(CMD_PLAY, 16'd20, 16'd0);
    add_cmd(CMD_PLAY, 16'd20, 16'd0);
    add_cmd(CMD_PLAY, 16'd20000, 16'd0);
    add_cmd(CMD_PLAY, 16'd19, 16'd0);
    add_cmd(CMD_PLAY, 16'd20001, 16'd0);
    add_cmd(CMD_PLAY, 16'd0, 16'd0);
    add_cmd(CMD_PLAY, 16'hFFFF, 16'hFFFF);
    add_cmd(CMD_BEEP, 16'd440, 16'd0);
    add_cmd(CMD_BEEP, 16'd440, 16'd3);
    add_cmd(CMD_TICK, 16'd0, 16'd0);
    add_cmd(CMD_TICK, 16'd0, 16'd0);
    add_cmd(CMD_TICK, 16'd0, 16'd0);
    add_cmd(CMD_TICK, 16'hFFFF, 16'hFFFF);
    add_cmd(CMD_PLAY, 16'd1000, 16'd0);
    add_cmd(CMD_BEEP, 16'd1000, 16'd2);
    add_cmd(CMD_PLAY, 16'd1000, 16'd0);
    add_cmd(CMD_BEEP, 16'd700, 16'hFFFF);
    add_cmd(CMD_TICK, 16'd0, 16'd0);
    add_cmd(CMD_STOP, 16'd0, 16'd0);
    add_cmd(CMD_STOP, 16'd0, 16'd0);
    add_cmd(CMD_BEEP, 16'd20000, 16'd1);
    add_cmd(CMD_TICK, 16'd0, 16'd0);
    add_random(320);
    drain();

    // fastest clock, widest band: large quotients clamp high
    set_regs(21'd2097151, 16'd1, 16'd65535);
    add_random(200);
    drain();

    // slowest clock: quotients clamp low
    set_regs(21'd1, 16'd1, 16'd65535);
    add_random(80);
    drain();

    // zero frequency allowed in band
    set_regs(TCLK_RST, 16'd0, 16'd100);
    add_cmd(CMD_PLAY, 16'd0, 16'd0);
    add_cmd(CMD_BEEP, 16'd0, 16'd2);
    add_random(130);
    drain();

    // empty band, every play and beep rejected
    set_regs(TCLK_RST, 16'd3000, 16'd200);
    add_random(40);
    drain();

    // single frequency band at the top
    set_regs(21'd1000000, 16'd65535, 16'd65535);
    add_random(40);
    drain();

    // random settings
    repeat (2) begin
      lo = FREQ_W'($urandom_range(1, 4000));
      set_regs(CLK_W'($urandom_range(1, 2097151)), lo, FREQ_W'($urandom_range(lo, 65535)));
      add_random(60);
      drain();
    end

    repeat (40) @(posedge clk_i);
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
